>>> src/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared constants, codes and controller/datapath interface types for the
// unique value set table.
// ----------------------------------------------------------------------------
`default_nettype none

package uvst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FOUND_W  = 6;

    localparam logic [2:0] CMD_INSERT     = 3'd0;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd1;
    localparam logic [2:0] CMD_REMOVE_POS = 3'd2;
    localparam logic [2:0] CMD_REPLACE    = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_BADPOS  = 3'd4
    } status_t;

    localparam logic signed [FOUND_W-1:0] FOUND_NONE = -6'sd1;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_en;
        logic update;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/uvst_ctrl.sv
// ----------------------------------------------------------------------------
// uvst_ctrl
// Sequencer: takes a command word, runs the table scan, then commits the
// update and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uvst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire uvst_pkg::dp_stat_t stat,
    output uvst_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.start   = 1'b0;
        cmd.scan_en = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // wait for the result register to free up
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> src/uvst_dp.sv
// ----------------------------------------------------------------------------
// uvst_dp
// Datapath: command register, table memory with one read and one write
// port, scan compare, fill count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uvst_dp (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire uvst_pkg::ctrl_cmd_t                      cmd,
    output uvst_pkg::dp_stat_t                            stat,
    input  wire logic [2:0]                               command,
    input  wire logic signed [uvst_pkg::DATA_W-1:0]       value,
    input  wire logic signed [uvst_pkg::DATA_W-1:0]       new_value,
    input  wire logic [3:0]                               position,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic [2:0]                                    status,
    output logic signed [uvst_pkg::FOUND_W-1:0]           found_position,
    output logic [uvst_pkg::CNT_W-1:0]                    entry_count
);

    localparam int IDX_W   = uvst_pkg::IDX_W;
    localparam int CNT_W   = uvst_pkg::CNT_W;
    localparam int DATA_W  = uvst_pkg::DATA_W;
    localparam int FOUND_W = uvst_pkg::FOUND_W;

    logic [DATA_W-1:0] mem [uvst_pkg::CAPACITY];

    // command word
    logic [2:0]        cmd_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] nval_reg;
    logic [3:0]        pos_reg;

    // scan
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              hit_v_reg;
    logic              hit_nv_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [DATA_W-1:0] last_reg;

    logic [CNT_W-1:0]  count_reg;

    // result register
    logic                      out_valid_reg;
    uvst_pkg::status_t         status_reg;
    logic signed [FOUND_W-1:0] found_reg;
    logic [CNT_W-1:0]          ecount_reg;

    // update decode
    uvst_pkg::status_t         st_next;
    logic signed [FOUND_W-1:0] found_next;
    logic [CNT_W-1:0]          count_next;
    logic                      wr_req;
    logic [IDX_W-1:0]          wr_addr;
    logic [DATA_W-1:0]         wr_data;
    logic                      rd_issue;

    assign rd_issue       = cmd.scan_en && (idx_reg < count_reg);
    assign stat.scan_done = (idx_reg == count_reg) && !rd_valid_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign entry_count    = ecount_reg;

    always_comb
    begin
        st_next    = uvst_pkg::ST_OK;
        found_next = '0;
        count_next = count_reg;
        wr_req     = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = last_reg;
        case (cmd_reg)
            uvst_pkg::CMD_INSERT:
            begin
                if (hit_v_reg)
                    st_next = uvst_pkg::ST_DUP;
                else if (count_reg >= CNT_W'(uvst_pkg::CAPACITY))
                    st_next = uvst_pkg::ST_FULL;
                else
                begin
                    wr_req     = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            uvst_pkg::CMD_REMOVE_VAL:
            begin
                if (!hit_v_reg)
                    st_next = uvst_pkg::ST_MISSING;
                else
                begin
                    // last entry moves into the freed slot
                    wr_req     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            uvst_pkg::CMD_REMOVE_POS:
            begin
                if (CNT_W'(pos_reg) >= count_reg)
                    st_next = uvst_pkg::ST_BADPOS;
                else
                begin
                    wr_req     = 1'b1;
                    wr_addr    = pos_reg[IDX_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            uvst_pkg::CMD_REPLACE:
            begin
                if (hit_nv_reg)
                    st_next = uvst_pkg::ST_DUP;
                else if (!hit_v_reg)
                    st_next = uvst_pkg::ST_MISSING;
                else
                begin
                    wr_req  = 1'b1;
                    wr_data = nval_reg;
                end
            end
            uvst_pkg::CMD_SEARCH:
            begin
                if (!hit_v_reg)
                begin
                    st_next    = uvst_pkg::ST_MISSING;
                    found_next = uvst_pkg::FOUND_NONE;
                end
                else
                    found_next = FOUND_W'(slot_reg) + FOUND_W'(1);
            end
            default:
            begin
                st_next = uvst_pkg::ST_OK;
            end
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_req)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    // command word and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg  <= command;
            val_reg  <= value;
            nval_reg <= new_value;
            pos_reg  <= position;
        end
        if (rd_issue)
            rd_idx_reg <= idx_reg;
        if (rd_valid_reg)
        begin
            if (rd_data_reg == val_reg && !hit_v_reg)
                slot_reg <= rd_idx_reg[IDX_W-1:0];
            if (rd_idx_reg == count_reg - CNT_W'(1))
                last_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_v_reg    <= 1'b0;
            hit_nv_reg   <= 1'b0;
        end
        else if (cmd.start)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_v_reg    <= 1'b0;
            hit_nv_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_issue;
            if (rd_issue)
                idx_reg <= idx_reg + CNT_W'(1);
            if (rd_valid_reg)
            begin
                if (rd_data_reg == val_reg)
                    hit_v_reg <= 1'b1;
                if (rd_data_reg == nval_reg)
                    hit_nv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg <= st_next;
            found_reg  <= found_next;
            ecount_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/unique_value_set_table_unit.sv
// ----------------------------------------------------------------------------
// unique_value_set_table_unit
// Table of up to sixteen distinct signed 32-bit values with a fill count:
// insert, remove by value, remove by position, replace and search.
// ----------------------------------------------------------------------------
// Each command word goes through these steps once accepted: the single
// read port of the table memory is swept, one stored entry per cycle; the
// last word read is compared; the controller sees the scan end; and an
// update step writes the table and loads the result register. With an
// empty table there is no entry to sweep or compare. The next word can be
// taken in the cycle after the update. A result still waiting in the
// result register delays the update until it is taken.
// Commands are handled one at a time; the result register lets the next
// command be taken while a result is still waiting. Removal moves the last
// entry into the freed slot, so entry order is not kept. No clearing is
// needed after reset: only slots below the count are ever read.
`default_nettype none

module unique_value_set_table_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [2:0]                          command,
    input  wire logic signed [uvst_pkg::DATA_W-1:0]  value,
    input  wire logic signed [uvst_pkg::DATA_W-1:0]  new_value,
    input  wire logic [3:0]                          position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [2:0]                               status,
    output logic signed [uvst_pkg::FOUND_W-1:0]      found_position,
    output logic [uvst_pkg::CNT_W-1:0]               entry_count
);

    uvst_pkg::ctrl_cmd_t cmd;
    uvst_pkg::dp_stat_t  stat;

    uvst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    uvst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .value          (value),
        .new_value      (new_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    // a taken word always blocks the input while its scan runs
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not stalled after taking a word");

    a_count_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= uvst_pkg::CNT_W'(uvst_pkg::CAPACITY))
    ) else $error("entry count above capacity");

    // only a search miss reports position -1
    a_miss_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && found_position == uvst_pkg::FOUND_NONE)
            |-> (status == uvst_pkg::ST_MISSING)
    ) else $error("position -1 without not-found status");

    // a word taken now cannot produce a result in the next cycle
    a_no_instant_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid
    ) else $error("result appeared without a scan");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unique value set table: directed command tests,
// then random command traffic in fill, mixed and drain phases, each result
// word checked against a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uvst_pkg::*;

    localparam int          RANDOM_WORDS      = 1430;
    localparam int          WATCHDOG_LIMIT    = 3000;
    localparam int          DRAIN_CYCLES      = 40;
    localparam int          MAX_PRINTED       = 50;
    localparam int          POOL_SIZE         = 48;
    localparam logic [2:0]  CMD_IGNORED_FIRST = 3'd5;
    localparam logic [2:0]  CMD_IGNORED_LAST  = 3'd7;
    localparam logic [31:0] VAL_MIN           = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX           = 32'h7FFF_FFFF;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

    typedef struct {
        status_t                    status;
        logic signed [FOUND_W-1:0]  found;
        logic [CNT_W-1:0]           count;
    } table_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [2:0]                 command;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   new_value;
    logic [3:0]                 position;
    logic                       out_valid;
    logic                       out_stall;
    logic [2:0]                 status;
    logic signed [FOUND_W-1:0]  found_position;
    logic [CNT_W-1:0]           entry_count;

    // behavioral copy of the table
    logic [DATA_W-1:0]  set_vals [CAPACITY];
    int unsigned        set_count;

    table_result_t      expected_q [$];
    logic [DATA_W-1:0]  value_pool [POOL_SIZE];
    int                 err_count;
    int                 burst_left;

    unique_value_set_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .value          (value),
        .new_value      (new_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------------
    function automatic int find_slot(logic [DATA_W-1:0] v);
        for (int i = 0; i < set_count && i < CAPACITY; i++)
        begin
            if (set_vals[i] == v)
                return i;
        end
        return CAPACITY;
    endfunction

    // last entry fills the freed slot
    function automatic void drop_entry(int slot);
        set_vals[slot] = set_vals[set_count - 1];
        set_count--;
    endfunction

    function automatic table_result_t apply_table_command(logic [2:0] cmd,
                                                          logic [DATA_W-1:0] v,
                                                          logic [DATA_W-1:0] nv,
                                                          logic [3:0] pos);
        table_result_t r;
        int            slot;
        r.status = ST_OK;
        r.found  = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (find_slot(v) != CAPACITY)
                    r.status = ST_DUP;
                else if (set_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    set_vals[set_count] = v;
                    set_count++;
                end
            end
            CMD_REMOVE_VAL:
            begin
                slot = find_slot(v);
                if (slot == CAPACITY)
                    r.status = ST_MISSING;
                else
                    drop_entry(slot);
            end
            CMD_REMOVE_POS:
            begin
                if (pos >= set_count)
                    r.status = ST_BADPOS;
                else
                    drop_entry(pos);
            end
            CMD_REPLACE:
            begin
                // presence of the new value is checked first
                if (find_slot(nv) != CAPACITY)
                    r.status = ST_DUP;
                else
                begin
                    slot = find_slot(v);
                    if (slot == CAPACITY)
                        r.status = ST_MISSING;
                    else
                        set_vals[slot] = nv;
                end
            end
            CMD_SEARCH:
            begin
                slot = find_slot(v);
                if (slot == CAPACITY)
                begin
                    r.status = ST_MISSING;
                    r.found  = FOUND_NONE;
                end
                else
                    r.found = FOUND_W'(slot + 1);
            end
            default:
                ;
        endcase
        r.count = CNT_W'(set_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        table_result_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result word status=%0d count=%0d",
                                          status, entry_count));
            else
            begin
                exp_word = expected_q.pop_front();
                if (status !== exp_word.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              status, exp_word.status.name()));
                if (found_position !== exp_word.found)
                    report_mismatch($sformatf("found_position %0d, expected %0d",
                                              found_position, exp_word.found));
                if (entry_count !== exp_word.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              entry_count, exp_word.count));
            end
        end
    end

    // no word moving on either side for too long ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] timeout: no word moved for %0d cycles", $realtime, quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure: free-running, random, or long stall stretches
    initial
    begin
        int mode;
        int mode_left;
        int hold;
        logic level;
        out_stall = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        level     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 35);
                default:
                begin
                    if (hold == 0)
                    begin
                        level = ~level;
                        hold  = level ? $urandom_range(5, 30) : $urandom_range(1, 6);
                    end
                    hold--;
                    out_stall <= level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_word(logic [2:0] cmd, logic [DATA_W-1:0] v,
                             logic [DATA_W-1:0] nv, logic [3:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        command   <= cmd;
        value     <= v;
        new_value <= nv;
        position  <= pos;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(apply_table_command(cmd, v, nv, pos));
    endtask

    // mostly values that collide with the table, some fully random
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (set_count > 0 && r < 40)
            return set_vals[$urandom_range(0, set_count - 1)];
        if (r < 80)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_position();
        if (set_count > 0 && $urandom_range(0, 99) < 70)
            return 4'($urandom_range(0, set_count - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [2:0] pick_command(traffic_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 60) return CMD_INSERT;
                if (r < 68) return CMD_REMOVE_VAL;
                if (r < 75) return CMD_REMOVE_POS;
                if (r < 87) return CMD_REPLACE;
                return CMD_SEARCH;
            end
            MODE_MIX:
            begin
                if (r < 28) return CMD_INSERT;
                if (r < 43) return CMD_REMOVE_VAL;
                if (r < 55) return CMD_REMOVE_POS;
                if (r < 75) return CMD_REPLACE;
                return CMD_SEARCH;
            end
            default:
            begin
                if (r < 12) return CMD_INSERT;
                if (r < 42) return CMD_REMOVE_VAL;
                if (r < 67) return CMD_REMOVE_POS;
                if (r < 78) return CMD_REPLACE;
                return CMD_SEARCH;
            end
        endcase
    endfunction

    task automatic test_insert_search();
        send_word(CMD_SEARCH, 32'd0, 32'd0, 4'd0);
        send_word(CMD_INSERT, VAL_MIN, 32'd0, 4'd0);
        send_word(CMD_INSERT, VAL_MAX, 32'd0, 4'd15);
        send_word(CMD_INSERT, 32'd0, VAL_MAX, 4'd0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, VAL_MIN, 4'd0);
        send_word(CMD_INSERT, VAL_MAX, 32'd0, 4'd0);
        send_word(CMD_SEARCH, VAL_MIN, 32'd0, 4'd0);
        send_word(CMD_SEARCH, 32'hFFFF_FFFF, 32'd0, 4'd0);
        send_word(CMD_SEARCH, 32'd5, 32'd0, 4'd0);
    endtask

    task automatic test_replace();
        send_word(CMD_REPLACE, 32'd0, 32'd0, 4'd0);
        send_word(CMD_REPLACE, VAL_MIN, VAL_MAX, 4'd0);
        send_word(CMD_REPLACE, 32'd12345, 32'd7, 4'd0);
        send_word(CMD_REPLACE, 32'd0, 32'h5555_AAAA, 4'd0);
    endtask

    task automatic test_remove();
        send_word(CMD_REMOVE_VAL, 32'd99, 32'd0, 4'd0);
        send_word(CMD_REMOVE_VAL, VAL_MIN, 32'd0, 4'd0);
        send_word(CMD_SEARCH, 32'hFFFF_FFFF, 32'd0, 4'd0);
        send_word(CMD_REMOVE_POS, 32'd0, 32'd0, 4'd15);
        send_word(CMD_REMOVE_POS, 32'd0, 32'd0, 4'd0);
        send_word(CMD_REMOVE_POS, 32'd0, 32'd0, 4'd2);
    endtask

    task automatic test_ignored_codes();
        for (int c = CMD_IGNORED_FIRST; c <= CMD_IGNORED_LAST; c++)
            send_word(3'(c), $urandom, $urandom, 4'($urandom_range(0, 15)));
    endtask

    task automatic test_random_traffic();
        traffic_mode_t mode;
        int            phase_left;
        int            sent;
        logic [2:0]    cmd;
        mode       = MODE_FILL;
        phase_left = 0;
        sent       = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (phase_left == 0)
            begin
                mode       = traffic_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(60, 200);
            end
            // occasional unused codes as noise, not counted
            if ($urandom_range(0, 99) < 3)
                cmd = 3'($urandom_range(CMD_IGNORED_FIRST, CMD_IGNORED_LAST));
            else
            begin
                cmd = pick_command(mode);
                sent++;
                phase_left--;
            end
            send_word(cmd, pick_value(), pick_value(), pick_position());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_INSERT;
        value      = '0;
        new_value  = '0;
        position   = '0;
        set_count  = 0;
        err_count  = 0;
        burst_left = 0;
        foreach (set_vals[i])
            set_vals[i] = '0;
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'd0;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'd1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_insert_search();
        test_replace();
        test_remove();
        test_ignored_codes();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
